FILE: rtl/qs_pkg.sv
// ----------------------------------------------------------------------------
// qs_pkg: shared types and constants of the quicksort sorter
// Holds the word layouts of both channels, the cell control word and the cell-to-cell link type.
// ----------------------------------------------------------------------------
package qs_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int DATA_W    = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_result;
    logic                     overflow;
  } out_word_t;

  typedef struct packed {
    logic                     load;
    logic                     shift;
    logic signed [DATA_W-1:0] data;
  } qs_ctrl_t;

  typedef struct packed {
    logic                     valid;
    logic                     gt;
    logic signed [DATA_W-1:0] value;
  } qs_link_t;

endpackage

FILE: rtl/qs_cell.sv
// ----------------------------------------------------------------------------
// qs_cell: one slot of the sorting chain
// Keeps one value in order, makes room for an inserted word by passing its
// value right, and passes values left while the run is read out.
// ----------------------------------------------------------------------------
module qs_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  qs_pkg::qs_ctrl_t ctrl,
  input  qs_pkg::qs_link_t left_i,
  input  qs_pkg::qs_link_t right_i,
  output qs_pkg::qs_link_t link_o
);
  import qs_pkg::*;

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;
  logic                     gt;

  // An empty slot counts as greater than any incoming word.
  assign gt = !valid_r || (value_r > ctrl.data);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.shift) begin
      valid_nxt = right_i.valid;
      value_nxt = right_i.value;
    end else if (ctrl.load) begin
      valid_nxt = valid_r | left_i.valid;
      if (gt) begin
        value_nxt = left_i.gt ? left_i.value : ctrl.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link_o.valid = valid_r;
  assign link_o.gt    = gt;
  assign link_o.value = value_r;

endmodule

FILE: rtl/quicksort_sorter.sv
// ----------------------------------------------------------------------------
// quicksort_sorter: sorts a run of signed 32-bit words in ascending order
// A chain of MAX_ITEMS cells keeps the stored words in order as they arrive.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_data) takes one word per cycle
// while in_stall is low. Each word is inserted into its sorted place as it
// is taken. A word with last_item set closes the run. Words beyond MAX_ITEMS
// are dropped, and every result of that run then carries overflow = 1. The
// closing word is dropped too if the chain is full. The first result appears
// on the output channel (out_valid, out_stall, out_data) in the cycle after
// the closing word is taken, then one result per cycle while the receiver
// does not stall; the results are read out by the left shift of the cell
// chain. The final result carries last_result = 1. While results are pending,
// in_stall is high; it drops in the cycle after the final result is taken.
// A stalled result holds its value. Reset empties the chain and returns to
// loading.
// ----------------------------------------------------------------------------
module quicksort_sorter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  qs_pkg::in_word_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output qs_pkg::out_word_t out_data
);
  import qs_pkg::*;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  state_t   state_r;
  logic     ovf_r;
  qs_ctrl_t ctrl;
  qs_link_t link [MAX_ITEMS];
  qs_link_t left_edge;
  qs_link_t right_edge;
  logic     [MAX_ITEMS-1:0] valid_vec;
  logic     in_acc;
  logic     out_acc;
  logic     full;

  assign full      = link[MAX_ITEMS-1].valid;
  assign in_stall  = (state_r == ST_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_EMIT) && link[0].valid;
  assign out_acc   = out_valid && !out_stall;

  assign ctrl.load  = in_acc && !full;
  assign ctrl.shift = out_acc;
  assign ctrl.data  = in_data.value;

  assign left_edge.valid  = 1'b1;
  assign left_edge.gt     = 1'b0;
  assign left_edge.value  = '0;
  assign right_edge.valid = 1'b0;
  assign right_edge.gt    = 1'b0;
  assign right_edge.value = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    qs_link_t left_l;
    qs_link_t right_l;
    if (i == 0) begin : g_first
      assign left_l = left_edge;
    end else begin : g_mid_l
      assign left_l = link[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_end
      assign right_l = right_edge;
    end else begin : g_mid_r
      assign right_l = link[i+1];
    end
    qs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .left_i  (left_l),
      .right_i (right_l),
      .link_o  (link[i])
    );
    assign valid_vec[i] = link[i].valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ovf_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            ovf_r <= ovf_r | full;
            if (in_data.last_item) begin
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_acc && !link[1].valid) begin
            state_r <= ST_LOAD;
            ovf_r   <= 1'b0;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_data.sorted_value = link[0].value;
  assign out_data.last_result  = !link[1].valid;
  assign out_data.overflow     = ovf_r;

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results are pending");

  a_fill_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + MAX_ITEMS'(1))) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_item) |=> out_valid)
    else $error("closing word did not start the read-out");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.last_result) |=> (!out_valid && valid_vec == '0))
    else $error("chain not empty after the final result");

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the quicksort sorter
// Runs of signed words go in, each closed by a marked word, and the sorted
// words that come back are checked field by field, most against a local
// quicksort of the same run. A short table of directed runs comes first, then
// random runs of mixed length and content, some of them longer than the store.
// Both sides idle at random, and the receiver once holds off for a long time.
// ----------------------------------------------------------------------------
module tb;
  import qs_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    bit                       last;
    bit                       typed;
    logic signed [DATA_W-1:0] want_value;
    bit                       want_last;
    bit                       want_ovf;
  } stim_row_t;

  localparam int RANDOM_WORDS = 425;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  bit        typed_now;
  out_word_t typed_want;

  int        run_store [MAX_ITEMS];
  int        run_count;
  bit        run_dropped;
  out_word_t sorted_due[$];

  int        words_sent;
  int        results_seen;
  int        runs_closed;
  int        overflow_runs;
  int        err_count;

  stim_row_t rows[$];

  quicksort_sorter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void sort_run();
    int lo_stack [MAX_ITEMS+1];
    int hi_stack [MAX_ITEMS+1];
    int sp;
    int lo;
    int hi;
    int li;
    int ri;
    int pivot;
    int t;
    sp = 0;
    if (run_count < 2) return;
    lo_stack[0] = 0;
    hi_stack[0] = run_count - 1;
    sp = 1;
    while (sp > 0) begin
      sp--;
      lo = lo_stack[sp];
      hi = hi_stack[sp];
      li = lo;
      ri = hi;
      pivot = run_store[lo + (hi - lo) / 2];
      while (li <= ri) begin
        while (li < hi && run_store[li] < pivot) li++;
        while (ri > lo && run_store[ri] > pivot) ri--;
        if (li <= ri) begin
          t = run_store[li];
          run_store[li] = run_store[ri];
          run_store[ri] = t;
          li++;
          ri--;
        end
      end
      if (li < hi && sp < MAX_ITEMS + 1) begin
        lo_stack[sp] = li;
        hi_stack[sp] = hi;
        sp++;
      end
      if (lo < ri && sp < MAX_ITEMS + 1) begin
        lo_stack[sp] = lo;
        hi_stack[sp] = ri;
        sp++;
      end
    end
  endfunction

  function automatic void take_word(in_word_t w);
    out_word_t r;
    if (run_count < MAX_ITEMS) begin
      run_store[run_count] = w.value;
      run_count++;
    end else begin
      run_dropped = 1'b1;
    end
    if (!w.last_item) return;
    sort_run();
    for (int k = 0; k < run_count; k++) begin
      r.sorted_value = run_store[k];
      r.last_result  = (k == run_count - 1);
      r.overflow     = run_dropped;
      sorted_due.push_back(r);
    end
    if (run_dropped) overflow_runs++;
    runs_closed++;
    run_count   = 0;
    run_dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      if (typed_now) begin
        sorted_due.push_back(typed_want);
        runs_closed++;
      end else begin
        take_word(in_data);
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (sorted_due.size() == 0) begin
        $error("unexpected word: sorted_value %0d", out_data.sorted_value);
        err_count++;
      end else begin
        want = sorted_due.pop_front();
        if (out_data.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d",
                 want.sorted_value, out_data.sorted_value);
          err_count++;
        end
        if (out_data.last_result !== want.last_result) begin
          $error("last_result: expected %0b, got %0b",
                 want.last_result, out_data.last_result);
          err_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
          err_count++;
        end
      end
    end
  end

  // Receiver: a random stall before each word, none in quiet stretches, with one long hold-off.
  initial begin
    int wait_cycles;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 25 == 0) quiet = ($urandom_range(0, 2) == 0);
      wait_cycles = quiet ? 0 : $urandom_range(0, 10);
      if (taken == HOLD_AT) wait_cycles = HOLD_CYCLES;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  task automatic send_word(in_word_t w, bit typed, out_word_t want, bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= w;
    typed_now  <= typed;
    typed_want <= want;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  initial begin
    in_word_t  w;
    out_word_t want;
    int        len;
    int        mode;
    int        base;
    int        step;
    bit        quiet;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    typed_now  <= 1'b0;
    typed_want <= '0;
    run_count   = 0;
    run_dropped = 1'b0;
    err_count   = 0;

    // Single-word runs come back unchanged; the rest go through the predictor.
    rows.push_back('{32'sh7fffffff, 1, 1, 32'sh7fffffff, 1, 0});
    rows.push_back('{32'sh80000000, 1, 1, 32'sh80000000, 1, 0});
    rows.push_back('{32'sh00000000, 1, 1, 32'sh00000000, 1, 0});
    rows.push_back('{32'shffffffff, 1, 1, 32'shffffffff, 1, 0});
    rows.push_back('{32'sd5, 0, 0, 0, 0, 0});
    rows.push_back('{-32'sd3, 0, 0, 0, 0, 0});
    rows.push_back('{32'sh7fffffff, 0, 0, 0, 0, 0});
    rows.push_back('{32'sh80000000, 0, 0, 0, 0, 0});
    rows.push_back('{32'sh55555555, 0, 0, 0, 0, 0});
    rows.push_back('{32'shaaaaaaaa, 0, 0, 0, 0, 0});
    rows.push_back('{-32'sd3, 0, 0, 0, 0, 0});
    rows.push_back('{32'sd1, 1, 0, 0, 0, 0});
    rows.push_back('{32'sd9, 0, 0, 0, 0, 0});
    rows.push_back('{32'sd9, 1, 0, 0, 0, 0});
    rows.push_back('{32'sd4, 0, 0, 0, 0, 0});
    rows.push_back('{32'sd3, 0, 0, 0, 0, 0});
    rows.push_back('{32'sd2, 0, 0, 0, 0, 0});
    rows.push_back('{32'sd1, 1, 0, 0, 0, 0});
    rows.push_back('{32'sd1, 0, 0, 0, 0, 0});
    rows.push_back('{32'sd2, 0, 0, 0, 0, 0});
    rows.push_back('{32'sd3, 1, 0, 0, 0, 0});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      w.value           = rows[i].value;
      w.last_item       = rows[i].last;
      want.sorted_value = rows[i].want_value;
      want.last_result  = rows[i].want_last;
      want.overflow     = rows[i].want_ovf;
      send_word(w, rows[i].typed, want, 1'b0);
    end

    want = '0;
    while (words_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 8);
        1:       len = MAX_ITEMS + $urandom_range(0, 1);
        default: len = $urandom_range(1, 12);
      endcase
      mode  = $urandom_range(0, 4);
      quiet = ($urandom_range(0, 3) == 0);
      base  = $urandom;
      step  = $urandom_range(0, 1000);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: w.value = $urandom;
          1: w.value = int'($urandom_range(0, 6)) - 3;
          2: w.value = base + i * step;
          3: w.value = base - i * step;
          default: begin
            case ($urandom_range(0, 4))
              0: w.value = 32'sh80000000;
              1: w.value = 32'sh7fffffff;
              2: w.value = 0;
              3: w.value = -1;
              default: w.value = 1;
            endcase
          end
        endcase
        w.last_item = (i == len - 1);
        send_word(w, 1'b0, want, quiet);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d words in %0d runs, %0d of them over capacity.",
             words_sent, runs_closed, overflow_runs);
    $display("Checked %0d sorted words with random idling on both sides.", results_seen);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/qs_pkg.sv
rtl/qs_cell.sv
rtl/quicksort_sorter.sv
bench/tb.sv
